// ----- src/rsits_pkg.sv -----
`default_nettype none

package rsits_pkg;

	// result fields are fixed at 16 bits
	localparam int FIELD_BITS = 16;
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = 16'hFFFF;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// character codes
	localparam logic [7:0] CHAR_R_LOWER = 8'h72;
	localparam logic [7:0] CHAR_R_UPPER = 8'h52;
	localparam logic [7:0] CHAR_S_LOWER = 8'h73;
	localparam logic [7:0] CHAR_S_UPPER = 8'h53;
	localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       doc_end;
	} byte_word_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] token_start;
		logic [FIELD_BITS-1:0] token_length;
	} token_word_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		logic is_r;
		logic is_s;
		logic is_digit;
		logic is_sep;
		logic last;
	} byte_class_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_R,
		PH_RS,
		PH_DIGITS
	} phase_t;

	function automatic logic is_sep_char(input logic [7:0] c);
		logic ws;
		logic punct;
		ws = ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
		punct = ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40))
			|| ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
		return ws || punct;
	endfunction

endpackage

`default_nettype wire

// ----- src/rs_identifier_token_scanner_unit.sv -----
`default_nettype none
// result path: the byte that closes a token passes through the queue and the match update
// into the result register, which then offers the token result
// throughput: one byte per cycle, unless a stalled token result holds back the matcher;
// a four-entry queue between classifier and matcher absorbs token-side stalls
// reset: asynchronous, active low; queue empties, matcher returns to idle at offset zero
// as at the start of a document, no result pending

module rs_identifier_token_scanner_unit
	import rsits_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// byte side
	input  wire                byte_valid,
	output logic               byte_stall,
	input  wire  byte_word_t   byte_word,
	// token side
	output logic               token_valid,
	input  wire                token_stall,
	output token_word_t        token_word
);

	byte_class_t cls_in;
	byte_class_t cls_out;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;

	// front: classify each byte as r, s, digit or delimiter
	rsits_front u_front (
		.byte_word (byte_word),
		.cls       (cls_in)
	);

	// queue decouples byte intake from the matcher; stall only when full
	rsits_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (byte_valid),
		.push_data (cls_in),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_data  (cls_out)
	);

	assign byte_stall = q_full;

	// back: match state machine, offset counters and the result register
	rsits_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cls_valid   (q_not_empty),
		.cls         (cls_out),
		.cls_pop     (q_pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_word  (token_word)
	);

endmodule

`default_nettype wire

// ----- src/rsits_front.sv -----
`default_nettype none

module rsits_front
	import rsits_pkg::*;
(
	input  wire  byte_word_t  byte_word,
	output byte_class_t       cls
);

	always_comb begin
		cls.is_r     = (byte_word.text_byte == CHAR_R_LOWER)
			|| (byte_word.text_byte == CHAR_R_UPPER);
		cls.is_s     = (byte_word.text_byte == CHAR_S_LOWER)
			|| (byte_word.text_byte == CHAR_S_UPPER);
		cls.is_digit = (byte_word.text_byte >= CHAR_DIGIT_LO)
			&& (byte_word.text_byte <= CHAR_DIGIT_HI);
		cls.is_sep   = is_sep_char(byte_word.text_byte);
		cls.last     = byte_word.doc_end;
	end

endmodule

`default_nettype wire

// ----- src/rsits_queue.sv -----
`default_nettype none

module rsits_queue
	import rsits_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire  byte_class_t  push_data,
	output logic               full,
	output logic               not_empty,
	input  wire                pop,
	output byte_class_t        pop_data
);

	byte_class_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full      = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/rsits_back.sv -----
`default_nettype none

module rsits_back
	import rsits_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cls_valid,
	input  wire  byte_class_t  cls,
	output logic               cls_pop,
	output logic               token_valid,
	input  wire                token_stall,
	output token_word_t        token_word
);

	localparam int WIDE_BITS = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;

	phase_t                 phase_q;
	phase_t                 phase_d;
	logic                   prev_delim_q;
	logic                   prev_delim_d;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] pos_d;
	logic [OFFSET_BITS-1:0] cand_q;
	logic [OFFSET_BITS-1:0] cand_d;
	logic [OFFSET_BITS-1:0] run_q;
	logic [OFFSET_BITS-1:0] run_d;
	logic                   emit;
	logic                   out_valid_q;
	token_word_t            out_word_q;

	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [FIELD_BITS-1:0] clip(input logic [OFFSET_BITS-1:0] v);
		logic [WIDE_BITS-1:0] ext;
		ext = WIDE_BITS'(v);
		return (ext > WIDE_BITS'(FIELD_MAX)) ? FIELD_MAX : ext[FIELD_BITS-1:0];
	endfunction

	// advance only when the output register can take a result
	assign cls_pop = cls_valid && (!out_valid_q || !token_stall);

	always_comb begin
		phase_d      = phase_q;
		cand_d       = cand_q;
		run_d        = run_q;
		emit         = 1'b0;
		unique case (phase_q)
			PH_R: begin
				if (cls.is_s) begin
					phase_d = PH_RS;
					run_d   = sat_inc(run_q);
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_RS: begin
				if (cls.is_digit) begin
					phase_d = PH_DIGITS;
					run_d   = sat_inc(run_q);
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DIGITS: begin
				if (cls.is_digit) begin
					run_d = sat_inc(run_q);
				end else begin
					emit    = cls.is_sep;
					phase_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				if (cls.is_r && prev_delim_q) begin
					phase_d = PH_R;
					cand_d  = pos_q;
					run_d   = OFFSET_BITS'(1);
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		prev_delim_d = cls.is_sep;
		pos_d        = sat_inc(pos_q);
		// end of document flushes a token still in its digits
		if (cls.last) begin
			if (phase_d == PH_DIGITS) begin
				emit = 1'b1;
			end
			phase_d      = PH_IDLE;
			prev_delim_d = 1'b1;
			pos_d        = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prev_delim_q <= 1'b1;
			pos_q        <= '0;
			cand_q       <= '0;
			run_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cls_pop) begin
				phase_q      <= phase_d;
				prev_delim_q <= prev_delim_d;
				pos_q        <= pos_d;
				cand_q       <= cand_d;
				run_q        <= run_d;
			end
			if (cls_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop && emit) begin
			out_word_q.token_start  <= clip(cand_d);
			out_word_q.token_length <= clip(run_d);
		end
	end

	assign token_valid = out_valid_q;
	assign token_word  = out_word_q;

endmodule

`default_nettype wire

// ----- src/rsits_checker.sv -----
`default_nettype none

module rsits_checker
	import rsits_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               byte_stall,
	input wire               token_valid,
	input wire               token_stall,
	input wire  token_word_t token_word
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("token dropped while stalled");

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token_word))
		else $error("token changed while stalled");

	// every token holds at least rs and one digit
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (token_word.token_length >= FIELD_BITS'(3)))
		else $error("token shorter than three bytes");

	// the queue only fills while the token side holds the matcher back
	assert property (@(posedge clk) disable iff (!arst_n)
		!(token_valid && token_stall) |=> !byte_stall)
		else $error("byte side stalled with free token side");

endmodule

bind rs_identifier_token_scanner_unit rsits_checker u_rsits_checker (.*);

`default_nettype wire
